[sv/tilt_to_pointer_motion_top_defines.svh]
// assertion macros shared by the tilt-to-pointer motion rtl
// no dependencies; the including module must provide clk_i and rst_ni
`ifndef TILT_TO_POINTER_MOTION_TOP_DEFINES_SVH
`define TILT_TO_POINTER_MOTION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define TPM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpm assertion failed");

`define TPM_ASSERT_NEVER(label, expr) \
  `TPM_ASSERT(label, !(expr))

`else

`define TPM_ASSERT(label, prop)

`define TPM_ASSERT_NEVER(label, expr)

`endif

`endif

[sv/tpm_pkg.sv]
// types, constants and the step ladder for the tilt-to-pointer motion block
// no dependencies
`default_nettype none

package tpm_pkg;

  typedef enum logic [1:0] {
    KIND_VERT = 2'd0,
    KIND_HORZ = 2'd1,
    KIND_LED  = 2'd2
  } kind_e;

  localparam int unsigned SampleW = 10;
  localparam int unsigned StepW   = 6;

  localparam logic [1:0] CFG_CENTER_V  = 2'd0;
  localparam logic [1:0] CFG_CENTER_H  = 2'd1;
  localparam logic [1:0] CFG_Z_THRESH  = 2'd2;

  localparam logic [SampleW-1:0] CENTER_V_RST = 10'd478;
  localparam logic [SampleW-1:0] CENTER_H_RST = 10'd565;
  localparam logic [SampleW-1:0] Z_THRESH_RST = 10'd300;

  localparam logic [SampleW:0] DEAD_ZONE = 11'd40;
  localparam logic [SampleW:0] LADDER_1  = 11'd50;
  localparam logic [SampleW:0] LADDER_2  = 11'd100;
  localparam logic [SampleW:0] LADDER_3  = 11'd150;
  localparam logic [SampleW:0] LADDER_4  = 11'd200;

  localparam logic [StepW-1:0] STEP_1  = 6'd1;
  localparam logic [StepW-1:0] STEP_2  = 6'd2;
  localparam logic [StepW-1:0] STEP_3  = 6'd3;
  localparam logic [StepW-1:0] STEP_6  = 6'd6;
  localparam logic [StepW-1:0] STEP_16 = 6'd16;

  // signed step for dev = center - mean, zero inside the dead zone
  function automatic logic signed [StepW-1:0] ladder_step(input logic signed [SampleW:0] dev);
    logic [SampleW:0] mag;
    logic [StepW-1:0] step;
    mag = dev[SampleW] ? (~dev + 11'd1) : dev;
    if (mag <= DEAD_ZONE) begin
      step = '0;
    end else if (mag < LADDER_1) begin
      step = STEP_1;
    end else if (mag < LADDER_2) begin
      step = STEP_2;
    end else if (mag < LADDER_3) begin
      step = STEP_3;
    end else if (mag < LADDER_4) begin
      step = STEP_6;
    end else begin
      step = STEP_16;
    end
    return (dev > 0) ? (~step + 6'd1) : step;
  endfunction

endpackage

`default_nettype wire

[sv/tilt_to_pointer_motion_top.sv]
// tilt-to-pointer motion block: frame averaging, dead zone, step ladder, report queue
// depends on tpm_pkg and tilt_to_pointer_motion_top_defines.svh
//
// usage
//   input channel (in_valid_i / in_ready_o) takes one sample triple plus the
//   button level per request, one per cycle while ready. every SAMPLES_PER_FRAME
//   requests form a frame; the button is taken from the first one.
//   output channel (out_valid_o / out_ready_i) gives, per frame, an optional
//   vertical report, an optional horizontal report, then the led result
//   with last_o set. mid-frame requests give no result.
//   the first result of a frame passes the sum register, the mean multiply
//   register and the ladder into the report register; results then leave
//   one per cycle while out_ready_i is high.
//   throughput: one sample per cycle. one frame is in flight behind the
//   accumulators, so the last sample of a frame waits while the previous
//   frame's results are not all taken; with SAMPLES_PER_FRAME of 6 or more
//   and a ready receiver this never stalls.
//   a stalled receiver holds the report register and, once the next frame
//   is at its last sample, the input channel; mid-frame samples are still taken.
//   reset clears sums, counter, pending results and loads the default
//   centers and threshold. configuration writes act at once.
`default_nettype none

module tilt_to_pointer_motion_top #(
  parameter int unsigned SAMPLES_PER_FRAME = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [9:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [9:0]        sample_vertical_i,
  input  wire logic [9:0]        sample_horizontal_i,
  input  wire logic [9:0]        sample_z_i,
  input  wire logic              button_pressed_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             kind_o,
  output logic                   buttons_o,
  output logic signed [5:0]      move_x_o,
  output logic signed [5:0]      move_y_o,
  output logic                   led_high_o,
  output logic                   last_o
);

  `include "tilt_to_pointer_motion_top_defines.svh"

  localparam int unsigned SW      = tpm_pkg::SampleW;
  localparam int unsigned LogN    = $clog2(SAMPLES_PER_FRAME);
  localparam int unsigned SumW    = SW + LogN;
  localparam int unsigned CntW    = (SAMPLES_PER_FRAME > 1) ? LogN : 1;
  localparam int unsigned Shift   = SumW + LogN + 1;
  localparam int unsigned RecipW  = Shift - LogN + 1;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + SAMPLES_PER_FRAME - 1) / SAMPLES_PER_FRAME;
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES_PER_FRAME - 1);

  // configuration
  logic [SW-1:0] center_v_q, center_h_q, z_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_v_q <= tpm_pkg::CENTER_V_RST;
      center_h_q <= tpm_pkg::CENTER_H_RST;
      z_thresh_q <= tpm_pkg::Z_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpm_pkg::CFG_CENTER_V: center_v_q <= cfg_wdata_i;
        tpm_pkg::CFG_CENTER_H: center_h_q <= cfg_wdata_i;
        tpm_pkg::CFG_Z_THRESH: z_thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accumulation
  logic [SumW-1:0] sum_v_q, sum_h_q, sum_z_q;
  logic [SumW-1:0] sum_v_d, sum_h_d, sum_z_d;
  logic [CntW-1:0] cnt_q;
  logic            btn_latch_q, btn_now;
  logic            last_sample, in_fire;

  // frame pipeline
  logic            tot_v_q, mean_v_q;
  logic [SumW-1:0] tot_v_sum_q, tot_h_sum_q, tot_z_sum_q;
  logic            tot_btn_q, mean_btn_q;
  logic [ProdW-1:0] prod_v, prod_h, prod_z;
  logic [SW-1:0]   mean_vert_q, mean_horz_q, mean_z_q;

  // report register, one valid bit per kind
  logic [2:0]              pend_v_q, pend_v_d;
  logic signed [5:0]       step_y_q, step_x_q, step_y_d, step_x_d;
  logic                    led_q, btn_q;
  logic                    frame_busy, out_fire;
  logic signed [SW:0]      dev_v, dev_h;
  tpm_pkg::kind_e          kind;

  assign last_sample = (cnt_q == LastCnt);
  assign frame_busy  = tot_v_q | mean_v_q | (|pend_v_q);
  assign in_ready_o  = !(last_sample && frame_busy);
  assign in_fire     = in_valid_i && in_ready_o;
  assign btn_now     = (cnt_q == '0) ? button_pressed_i : btn_latch_q;

  assign sum_v_d = sum_v_q + SumW'(sample_vertical_i);
  assign sum_h_d = sum_h_q + SumW'(sample_horizontal_i);
  assign sum_z_d = sum_z_q + SumW'(sample_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q     <= '0;
      sum_h_q     <= '0;
      sum_z_q     <= '0;
      cnt_q       <= '0;
      btn_latch_q <= 1'b0;
      tot_v_q     <= 1'b0;
    end else begin
      tot_v_q <= in_fire && last_sample;
      if (in_fire) begin
        btn_latch_q <= btn_now;
        if (last_sample) begin
          sum_v_q <= '0;
          sum_h_q <= '0;
          sum_z_q <= '0;
          cnt_q   <= '0;
        end else begin
          sum_v_q <= sum_v_d;
          sum_h_q <= sum_h_d;
          sum_z_q <= sum_z_d;
          cnt_q   <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_sample) begin
      tot_v_sum_q <= sum_v_d;
      tot_h_sum_q <= sum_h_d;
      tot_z_sum_q <= sum_z_d;
      tot_btn_q   <= btn_now;
    end
  end

  // floor mean by reciprocal multiply, exact over the whole sum range
  assign prod_v = ProdW'(tot_v_sum_q) * ProdW'(Recip);
  assign prod_h = ProdW'(tot_h_sum_q) * ProdW'(Recip);
  assign prod_z = ProdW'(tot_z_sum_q) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_v_q <= 1'b0;
    end else begin
      mean_v_q <= tot_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tot_v_q) begin
      mean_vert_q <= prod_v[Shift +: SW];
      mean_horz_q <= prod_h[Shift +: SW];
      mean_z_q    <= prod_z[Shift +: SW];
      mean_btn_q  <= tot_btn_q;
    end
  end

  // dead zone and ladder
  assign dev_v    = $signed({1'b0, center_v_q}) - $signed({1'b0, mean_vert_q});
  assign dev_h    = $signed({1'b0, center_h_q}) - $signed({1'b0, mean_horz_q});
  assign step_y_d = tpm_pkg::ladder_step(dev_v);
  assign step_x_d = tpm_pkg::ladder_step(dev_h);

  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    pend_v_d = pend_v_q;
    if (out_fire) begin
      if (pend_v_q[tpm_pkg::KIND_VERT]) begin
        pend_v_d[tpm_pkg::KIND_VERT] = 1'b0;
      end else if (pend_v_q[tpm_pkg::KIND_HORZ]) begin
        pend_v_d[tpm_pkg::KIND_HORZ] = 1'b0;
      end else begin
        pend_v_d[tpm_pkg::KIND_LED] = 1'b0;
      end
    end
    if (mean_v_q) begin
      pend_v_d = {1'b1, (step_x_d != '0), (step_y_d != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= '0;
    end else begin
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mean_v_q) begin
      step_y_q <= step_y_d;
      step_x_q <= step_x_d;
      led_q    <= (mean_z_q >= z_thresh_q);
      btn_q    <= mean_btn_q;
    end
  end

  // output selection
  always_comb begin
    if (pend_v_q[tpm_pkg::KIND_VERT]) begin
      kind = tpm_pkg::KIND_VERT;
    end else if (pend_v_q[tpm_pkg::KIND_HORZ]) begin
      kind = tpm_pkg::KIND_HORZ;
    end else begin
      kind = tpm_pkg::KIND_LED;
    end
  end

  assign out_valid_o = |pend_v_q;
  assign kind_o      = kind;
  assign buttons_o   = btn_q;
  assign move_y_o    = (kind == tpm_pkg::KIND_VERT) ? step_y_q : '0;
  assign move_x_o    = (kind == tpm_pkg::KIND_HORZ) ? step_x_q : '0;
  assign led_high_o  = (kind == tpm_pkg::KIND_LED) ? led_q : 1'b0;
  assign last_o      = (kind == tpm_pkg::KIND_LED);

  // checks
  `TPM_ASSERT(a_one_frame, $countones({tot_v_q, mean_v_q, |pend_v_q}) <= 1)
  `TPM_ASSERT(a_tot_to_mean, tot_v_q |=> mean_v_q)
  `TPM_ASSERT(a_mean_to_report, mean_v_q |=> pend_v_q[tpm_pkg::KIND_LED])
  `TPM_ASSERT(a_led_closes, (|pend_v_q) |-> pend_v_q[tpm_pkg::KIND_LED])
  `TPM_ASSERT_NEVER(a_cnt_range, cnt_q > LastCnt)

endmodule

`default_nettype wire
